// File: rtl/core/lrss_pkg.sv
// Package for the lidar return select and scan split core.
// Payload structs, return type and mode codes, register indexes.
// No dependencies.
`default_nettype none

package lrss_pkg;

  localparam logic [15:0] AZIMUTH_STEPS = 16'd36000;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PHASE = 3'd3;

  typedef enum logic [1:0] {
    MODE_DUAL      = 2'd0,
    MODE_STRONGEST = 2'd1,
    MODE_LAST      = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    RT_STRONGEST  = 3'd0,
    RT_LAST       = 3'd1,
    RT_IDENTICAL  = 3'd2,
    RT_FIRST_WEAK = 3'd3,
    RT_LAST_WEAK  = 3'd4
  } ret_type_e;

  typedef struct packed {
    logic [1:0]  echo_mode;
    logic        packet_start;
    logic        block_start;
    logic [15:0] azimuth;
    logic [5:0]  laser;
    logic [15:0] even_range;
    logic [7:0]  even_intensity;
    logic [15:0] odd_range;
    logic [7:0]  odd_intensity;
  } lrss_in_t;

  typedef struct packed {
    logic [5:0]  out_laser;
    logic [15:0] out_range;
    logic [7:0]  out_intensity;
    ret_type_e   echo_type;
    logic        next_scan;
    logic        last_of_run;
  } lrss_out_t;

endpackage

`default_nettype wire

// File: rtl/core/lrss_stream_if.sv
// Valid/ready stream interface carrying one payload item per handshake.
// Payload type is a parameter; used with the structs of lrss_pkg.
`default_nettype none

interface lrss_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lidar_return_select_scan_split_core.sv
// Dual-return selection and scan split core for a spinning lidar.
// Depends on lrss_pkg and lrss_stream_if.
`default_nettype none

// One laser measurement enters per item and yields zero, one or two points.
// An item is held in an input register while its points move into the
// single output register, which sets the rate: one point per cycle while
// the output is not stalled. A new item is taken in the cycle its
// predecessor emits its last point, or while the input register is empty
// even if a finished point still waits on the output side. Scan wrap state
// updates when an item leaves the input register. Registers are written
// through cfg_we_i/cfg_idx_i/cfg_data_i by the user only while the core is
// idle; the core does not enforce it. Indexes past the list are ignored.
module lidar_return_select_scan_split_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [lrss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [lrss_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lrss_stream_if.sink                     in_i,
  lrss_stream_if.source                   out_o
);
  import lrss_pkg::*;

  typedef struct packed {
    logic [15:0] range;
    logic [7:0]  intensity;
    ret_type_e   rtype;
  } point_t;

  logic [15:0] min_range_q, max_range_q, close_thr_q, scan_phase_q;
  logic        wrapped_q, wrapped_d;
  logic [15:0] prev_phase_q, prev_phase_d;

  logic      s1_valid_q, s1_second_q;
  lrss_in_t  s1_q;
  logic      out_valid_q;
  lrss_out_t out_data_q;

  logic        in_hs, out_load, emit, retire;
  logic [15:0] az_mod, sp_mod, phase;
  logic        wrapped_clr;
  logic        even_ok, odd_ok, close_hit, even_strong;
  logic [15:0] diff;
  logic [1:0]  n_pts;
  point_t      pt0, pt1, pt_sel;
  point_t      even_pt, odd_pt;

  always_comb begin
    az_mod = (s1_q.azimuth >= AZIMUTH_STEPS) ? s1_q.azimuth - AZIMUTH_STEPS : s1_q.azimuth;
    sp_mod = (scan_phase_q >= AZIMUTH_STEPS) ? scan_phase_q - AZIMUTH_STEPS : scan_phase_q;
    phase  = (az_mod >= sp_mod) ? az_mod - sp_mod : az_mod + (AZIMUTH_STEPS - sp_mod);

    wrapped_clr  = s1_q.packet_start ? 1'b0 : wrapped_q;
    wrapped_d    = wrapped_clr;
    prev_phase_d = prev_phase_q;
    if (s1_q.block_start) begin
      wrapped_d    = wrapped_clr | (phase <= prev_phase_q);
      prev_phase_d = phase;
    end
  end

  always_comb begin
    even_ok     = (s1_q.even_range >= min_range_q) && (s1_q.even_range <= max_range_q);
    odd_ok      = (s1_q.odd_range >= min_range_q) && (s1_q.odd_range <= max_range_q);
    diff        = (s1_q.even_range >= s1_q.odd_range) ? s1_q.even_range - s1_q.odd_range
                                                      : s1_q.odd_range - s1_q.even_range;
    close_hit   = (diff < close_thr_q) && even_ok;
    even_strong = s1_q.even_intensity >= s1_q.odd_intensity;

    even_pt = '{range: s1_q.even_range, intensity: s1_q.even_intensity,
                rtype: even_strong ? RT_STRONGEST : RT_LAST_WEAK};
    odd_pt  = '{range: s1_q.odd_range, intensity: s1_q.odd_intensity,
                rtype: even_strong ? RT_FIRST_WEAK : RT_STRONGEST};

    pt1 = even_pt;
    if (s1_q.echo_mode != MODE_DUAL) begin
      n_pts = 2'd1;
      pt0   = '{range: s1_q.even_range, intensity: s1_q.even_intensity,
                rtype: (s1_q.echo_mode == MODE_STRONGEST) ? RT_STRONGEST : RT_LAST};
    end else if (close_hit) begin
      n_pts = 2'd1;
      pt0   = '{range: s1_q.even_range, intensity: s1_q.even_intensity,
                rtype: RT_IDENTICAL};
    end else begin
      n_pts = {1'b0, odd_ok} + {1'b0, even_ok};
      pt0   = odd_ok ? odd_pt : even_pt;
    end
    pt_sel = s1_second_q ? pt1 : pt0;
  end

  assign out_load = !out_valid_q || out_o.ready;
  assign emit     = s1_valid_q && (n_pts != 2'd0) && out_load;
  assign retire   = s1_valid_q && ((n_pts == 2'd0) ||
                                   (emit && ((n_pts == 2'd1) || s1_second_q)));
  assign in_i.ready  = !s1_valid_q || retire;
  assign in_hs       = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q  <= '0;
      max_range_q  <= 16'hFFFF;
      close_thr_q  <= '0;
      scan_phase_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_RANGE:       min_range_q  <= cfg_data_i;
        REG_MAX_RANGE:       max_range_q  <= cfg_data_i;
        REG_CLOSE_THRESHOLD: close_thr_q  <= cfg_data_i;
        REG_SCAN_PHASE:      scan_phase_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrapped_q    <= 1'b0;
      prev_phase_q <= '0;
      s1_valid_q   <= 1'b0;
      s1_second_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (retire) begin
        wrapped_q    <= wrapped_d;
        prev_phase_q <= prev_phase_d;
      end
      if (in_hs) begin
        s1_valid_q <= 1'b1;
      end else if (retire) begin
        s1_valid_q <= 1'b0;
      end
      if (retire) begin
        s1_second_q <= 1'b0;
      end else if (emit) begin
        s1_second_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      s1_q <= in_i.data;
    end
    if (emit) begin
      out_data_q <= '{out_laser: s1_q.laser, out_range: pt_sel.range,
                      out_intensity: pt_sel.intensity, echo_type: pt_sel.rtype,
                      next_scan: wrapped_d,
                      last_of_run: (n_pts == 2'd1) || s1_second_q};
    end
  end

  a_second_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_second_q |-> s1_valid_q)
    else $error("second point pending without a held item");

  a_second_retires: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_second_q && emit) |-> retire)
    else $error("item not retired after its second point");

  a_retire_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (retire && !in_hs) |=> (!s1_valid_q && !s1_second_q))
    else $error("input register still busy after retire");

  a_pair_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !retire) |=> (s1_valid_q && s1_second_q))
    else $error("first of two points emitted but item dropped");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Testbench for lidar_return_select_scan_split_core: directed and random items with
// random stalls on both streams, checked point by point against a behavioral predictor.
// Depends on lrss_pkg, lrss_stream_if and the core.
module tb_top;
  import lrss_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS = 85;
  localparam logic [1:0]  MODE_UNLISTED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lrss_stream_if #(.T(lrss_in_t))  in_if ();
  lrss_stream_if #(.T(lrss_out_t)) out_if ();

  // Predicts the points of each accepted item and checks the emitted ones in order.
  class point_scoreboard;
    logic [15:0] min_rng, max_rng, close_thr, scan_ofs, last_phase;
    bit          wrapped;
    lrss_out_t   pending_q[$];
    int          errors, points_checked;

    function new();
      min_rng        = 16'd0;
      max_rng        = 16'hFFFF;
      close_thr      = 16'd0;
      scan_ofs       = 16'd0;
      last_phase     = 16'd0;
      wrapped        = 1'b0;
      errors         = 0;
      points_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_MIN_RANGE:       min_rng = val;
        REG_MAX_RANGE:       max_rng = val;
        REG_CLOSE_THRESHOLD: close_thr = val;
        REG_SCAN_PHASE:      scan_ofs = val;
        default: ;
      endcase
    endfunction

    function bit usable(logic [15:0] r);
      return r >= min_rng && r <= max_rng;
    endfunction

    function lrss_out_t make_point(logic [5:0] laser, logic [15:0] rng, logic [7:0] inten,
                                   ret_type_e kind);
      lrss_out_t p;
      p.out_laser     = laser;
      p.out_range     = rng;
      p.out_intensity = inten;
      p.echo_type     = kind;
      p.next_scan     = wrapped;
      p.last_of_run   = 1'b0;
      return p;
    endfunction

    function void note_measurement(lrss_in_t m);
      int unsigned steps, phase, spread;
      bit          even_ok, odd_ok;
      lrss_out_t   run[$];
      steps = AZIMUTH_STEPS;
      if (m.packet_start) wrapped = 1'b0;
      if (m.block_start) begin
        phase = (m.azimuth % steps + steps - scan_ofs % steps) % steps;
        if (phase <= last_phase || wrapped) wrapped = 1'b1;
        last_phase = phase[15:0];
      end
      if (m.echo_mode != MODE_DUAL) begin
        if (m.echo_mode == MODE_STRONGEST)
          run.push_back(make_point(m.laser, m.even_range, m.even_intensity, RT_STRONGEST));
        else
          run.push_back(make_point(m.laser, m.even_range, m.even_intensity, RT_LAST));
      end else begin
        even_ok = usable(m.even_range);
        odd_ok  = usable(m.odd_range);
        spread = (m.even_range >= m.odd_range) ? m.even_range - m.odd_range
                                               : m.odd_range - m.even_range;
        if (spread < close_thr && even_ok) begin
          run.push_back(make_point(m.laser, m.even_range, m.even_intensity, RT_IDENTICAL));
        end else if (m.even_intensity >= m.odd_intensity) begin
          if (odd_ok)
            run.push_back(make_point(m.laser, m.odd_range, m.odd_intensity, RT_FIRST_WEAK));
          if (even_ok)
            run.push_back(make_point(m.laser, m.even_range, m.even_intensity, RT_STRONGEST));
        end else begin
          if (odd_ok)
            run.push_back(make_point(m.laser, m.odd_range, m.odd_intensity, RT_STRONGEST));
          if (even_ok)
            run.push_back(make_point(m.laser, m.even_range, m.even_intensity, RT_LAST_WEAK));
        end
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[k]) pending_q.push_back(run[k]);
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_point(lrss_out_t got);
      lrss_out_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected point, expected none, actual laser %0d range %0d",
                 $time, got.out_laser, got.out_range);
        return;
      end
      want = pending_q.pop_front();
      points_checked++;
      compare("out_laser", want.out_laser, got.out_laser);
      compare("out_range", want.out_range, got.out_range);
      compare("out_intensity", want.out_intensity, got.out_intensity);
      compare("echo_type", want.echo_type, got.echo_type);
      compare("next_scan", want.next_scan, got.next_scan);
      compare("last_of_run", want.last_of_run, got.last_of_run);
    endfunction
  endclass

  point_scoreboard sb = new();
  int              items_sent;
  int              settings_used;
  int              idle_cycles;
  int unsigned     az_run;
  bit              steady;

  lidar_return_select_scan_split_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Handshake monitor and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_if.valid && in_if.ready) sb.note_measurement(in_if.data);
      if (out_if.valid && out_if.ready) sb.check_point(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Point sink with random stalls.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic send_item(lrss_in_t m);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= m;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [15:0] lo, logic [15:0] hi, logic [15:0] thr,
                                logic [15:0] ofs);
    settle();
    write_cfg(REG_MIN_RANGE, lo);
    write_cfg(REG_MAX_RANGE, hi);
    write_cfg(REG_CLOSE_THRESHOLD, thr);
    write_cfg(REG_SCAN_PHASE, ofs);
    // unused index, must have no effect
    write_cfg(CFG_IDX_W'(4 + $urandom_range(0, 3)), 16'($urandom));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic lrss_in_t meas(logic [1:0] mode, bit ps, bit bs, logic [15:0] az,
                                    logic [5:0] laser, logic [15:0] er, logic [7:0] ei,
                                    logic [15:0] orr, logic [7:0] oi);
    lrss_in_t m;
    m.echo_mode      = mode;
    m.packet_start   = ps;
    m.block_start    = bs;
    m.azimuth        = az;
    m.laser          = laser;
    m.even_range     = er;
    m.even_intensity = ei;
    m.odd_range      = orr;
    m.odd_intensity  = oi;
    return m;
  endfunction

  // Ranges biased toward the gate edges.
  function automatic logic [15:0] pick_range();
    case ($urandom_range(0, 7))
      0: return sb.min_rng;
      1: return sb.min_rng - 16'd1;
      2: return sb.max_rng;
      3: return sb.max_rng + 16'd1;
      4: return (sb.min_rng <= sb.max_rng) ? 16'($urandom_range(sb.min_rng, sb.max_rng))
                                           : 16'($urandom);
      5: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Second return close to the first, around the identical threshold.
  function automatic logic [15:0] near_range(logic [15:0] er);
    int lim, d;
    lim = (sb.close_thr > 300) ? 300 : int'(sb.close_thr) + 2;
    case ($urandom_range(0, 3))
      0: d = sb.close_thr;
      1: d = int'(sb.close_thr) - 1;
      default: d = $urandom_range(0, lim);
    endcase
    if ($urandom_range(0, 1)) d = -d;
    return 16'(int'(er) + d);
  endfunction

  function automatic lrss_in_t random_meas(logic [1:0] mode);
    lrss_in_t m;
    m = '0;
    m.echo_mode      = mode;
    m.even_range     = pick_range();
    m.odd_range      = $urandom_range(0, 1) ? near_range(m.even_range) : pick_range();
    m.even_intensity = 8'($urandom);
    m.odd_intensity  = ($urandom_range(0, 4) == 0) ? m.even_intensity : 8'($urandom);
    return m;
  endfunction

  task automatic send_packet();
    int unsigned pick;
    logic [1:0]  mode;
    int          n_blocks, n_lasers, base;
    lrss_in_t    m;
    pick = $urandom_range(0, 9);
    if (pick < 6)      mode = MODE_DUAL;
    else if (pick < 8) mode = MODE_STRONGEST;
    else if (pick < 9) mode = MODE_LAST;
    else               mode = MODE_UNLISTED;
    steady   = ($urandom_range(0, 5) == 0);
    n_blocks = $urandom_range(1, 4);
    for (int b = 0; b < n_blocks; b++) begin
      if ($urandom_range(0, 7) == 0) az_run = $urandom_range(0, 35999);
      else az_run = (az_run + $urandom_range(0, 400)) % 36000;
      n_lasers = $urandom_range(1, 5);
      base     = $urandom_range(0, 39);
      for (int k = 0; k < n_lasers; k++) begin
        m = random_meas(mode);
        m.packet_start = (b == 0 && k == 0);
        m.block_start  = (k == 0);
        m.azimuth      = 16'(az_run);
        m.laser        = 6'((base + k) % 40);
        send_item(m);
      end
    end
  endtask

  task automatic send_noise();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    send_item(raw[$bits(lrss_in_t)-1:0]);
  endtask

  task automatic run_phase();
    int start;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_packet();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    steady        = 1'b0;
    az_run        = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: first block wraps, single modes, out-of-range azimuth
    send_item(meas(MODE_DUAL, 1, 1, 16'd0, 6'd0, 16'd0, 8'd0, 16'hFFFF, 8'd255));
    send_item(meas(MODE_STRONGEST, 0, 0, 16'd0, 6'd39, 16'hFFFF, 8'd255, 16'd0, 8'd0));
    send_item(meas(MODE_LAST, 1, 1, 16'd35999, 6'd1, 16'd1234, 8'd12, 16'd0, 8'd0));
    send_item(meas(MODE_UNLISTED, 0, 0, 16'd35999, 6'd63, 16'd777, 8'd1, 16'hFFFF, 8'd255));
    send_item(meas(MODE_DUAL, 0, 1, 16'hFFFF, 6'd5, 16'd500, 8'd200, 16'd500, 8'd200));
    send_item(meas(MODE_DUAL, 1, 1, 16'd100, 6'd2, 16'd0, 8'd0, 16'd0, 8'd0));
    send_item(meas(MODE_DUAL, 1, 1, 16'd200, 6'd3, 16'd42, 8'd9, 16'd43, 8'd8));

    // gate, threshold and scan offset
    apply_settings(16'd100, 16'd60000, 16'd50, 16'd35999);
    send_item(meas(MODE_DUAL, 1, 1, 16'd35999, 6'd4, 16'd1000, 8'd10, 16'd1049, 8'd20));
    send_item(meas(MODE_DUAL, 0, 0, 16'd35999, 6'd5, 16'd1000, 8'd10, 16'd1050, 8'd20));
    send_item(meas(MODE_DUAL, 0, 0, 16'd35999, 6'd6, 16'd99, 8'd30, 16'd120, 8'd30));
    send_item(meas(MODE_DUAL, 0, 0, 16'd35999, 6'd7, 16'd60001, 8'd1, 16'd50, 8'd2));
    send_item(meas(MODE_DUAL, 0, 0, 16'd35999, 6'd8, 16'd100, 8'd3, 16'd60000, 8'd3));
    send_item(meas(MODE_STRONGEST, 0, 0, 16'd35999, 6'd9, 16'd5, 8'd4, 16'd0, 8'd0));
    send_item(meas(MODE_LAST, 0, 0, 16'd35999, 6'd10, 16'hFFFF, 8'd5, 16'd0, 8'd0));
    send_item(meas(MODE_DUAL, 1, 1, 16'd0, 6'd11, 16'd2000, 8'd50, 16'd3000, 8'd40));

    // out-of-range scan offset, widest threshold, tightest gate
    apply_settings(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    send_item(meas(MODE_DUAL, 1, 1, 16'd29535, 6'd12, 16'd0, 8'd7, 16'd0, 8'd6));
    send_item(meas(MODE_DUAL, 0, 0, 16'd29535, 6'd13, 16'd1, 8'd7, 16'd0, 8'd6));
    send_item(meas(MODE_DUAL, 0, 1, 16'd29536, 6'd14, 16'd0, 8'd1, 16'd9, 8'd2));

    apply_settings(16'd0, 16'hFFFF, 16'd0, 16'd0);
    run_phase();
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd18000);
    run_phase();
    apply_settings(16'd0, 16'd0, 16'd1, 16'd35999);
    run_phase();
    repeat (2) begin
      apply_settings(16'($urandom_range(0, 2000)), 16'($urandom_range(30000, 65535)),
                     16'($urandom_range(0, 300)), 16'($urandom_range(0, 35999)));
      run_phase();
    end
    apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase();

    settle();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d items under %0d register settings, %0d points checked.",
             items_sent, settings_used, sb.points_checked);
    $display("Mismatches: %0d, points still expected: %0d.", sb.errors, sb.pending_q.size());
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
